// ===== rtl/core/galp_pkg.sv =====
// Shared constants and types for the adaptive gravity low-pass filter.
package galp_pkg;

    localparam int SAMPLE_W    = 20;
    localparam int TIME_W      = 48;
    localparam int FRAC_W      = 16;
    localparam int GRAV_W      = 16;
    localparam int G_W         = 15;
    localparam int TAU_W       = 24;
    localparam int THR_W       = 16;
    localparam int NORM_W      = 20;
    localparam int SQ_W        = 40;
    localparam int DIV_W       = 49;
    localparam int DIV_CNT_W   = 6;
    localparam int SQRT_CNT_W  = 5;
    localparam int ALPHA_W     = FRAC_W + 1;
    localparam int PROD_W      = 34;
    localparam int BLEND_W     = 35;
    localparam int LANES       = 3;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 104;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_GRAV     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAU_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAU_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAU_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_HIGH = 3'd5;

    typedef struct packed {
        logic load;
        logic scale_go;
        logic blend_go;
    } lane_cmd_t;

    typedef struct packed {
        logic scale_done;
        logic blend_done;
    } lane_sts_t;

endpackage

// ===== rtl/core/gravity_adaptive_lowpass_top.sv =====
// Top level of the adaptive gravity low-pass filter: control, shared units and lanes.
// One accelerometer item is taken at a time, either without history or with history (blend
// and a second normalisation); the next item is accepted only after the result is loaded.
// The work is done by bit-serial square roots and divisions (lanes, shared divider).
// Other items are accepted and dropped. One item is in work at a time.
// Synchronous active-low reset restores register defaults and clears the history.
module gravity_adaptive_lowpass_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // accel_x, accel_y, accel_z, accuracy_in, timestamp_us
    input  logic [galp_pkg::IN_DATA_W-1:0]      s_tdata,
    // accel_event
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // grav_x, grav_y, grav_z, accuracy_out, time_out
    output logic [galp_pkg::OUT_DATA_W-1:0]     m_tdata,
    // zero_norm
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [galp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [galp_pkg::CFG_W-1:0]          cfg_wdata
);
    import galp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_LOADW = 8'b00000010,
        ST_SQS   = 8'b00000100,
        ST_SQRT  = 8'b00001000,
        ST_SCALE = 8'b00010000,
        ST_ALPHA = 8'b00100000,
        ST_BLEND = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [G_W-1:0]   grav_reg;
    logic [TAU_W-1:0] tau_low_reg, tau_mid_reg, tau_high_reg;
    logic [THR_W-1:0] err_low_reg, err_high_reg;

    logic [TIME_W-1:0]        prev_time_reg;
    logic signed [GRAV_W-1:0] prev_g_reg [LANES];
    logic [TIME_W-1:0]        ts_reg;
    logic [2:0]               acc_reg;
    logic                     pass2_reg;
    logic                     zero_reg;

    logic                     m_valid_reg;
    logic [OUT_DATA_W-1:0]    m_data_reg;
    logic                     m_user_reg;

    lane_cmd_t                lane_cmd;
    lane_sts_t                lane_sts [LANES];
    logic [SQ_W-1:0]          lane_sq [LANES];
    logic signed [GRAV_W-1:0] lane_scaled [LANES];
    logic signed [SAMPLE_W-1:0] lane_in [LANES];
    logic [ALPHA_W-1:0]       lane_alpha;
    logic                     lanes_scaled;
    logic                     lanes_blended;

    logic [SQ_W-1:0]   sq_sum;
    logic              sqrt_start, sqrt_done;
    logic [NORM_W-1:0] sqrt_root;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_num, div_den, div_quot;

    logic              accept;
    logic              out_load;
    logic [NORM_W-1:0] g_ext, diff;
    logic              big_err;
    logic [TAU_W-1:0]  tau;
    logic [TIME_W-1:0] dt;
    logic [DIV_W-1:0]  a_den, a_num;

    assign lane_in[0] = s_tdata[19:0];
    assign lane_in[1] = s_tdata[39:20];
    assign lane_in[2] = s_tdata[59:40];

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign lanes_scaled  = lane_sts[0].scale_done & lane_sts[1].scale_done &
                           lane_sts[2].scale_done;
    assign lanes_blended = lane_sts[0].blend_done & lane_sts[1].blend_done &
                           lane_sts[2].blend_done;

    always_comb begin
        sq_sum  = lane_sq[0] + lane_sq[1] + lane_sq[2];
        g_ext   = NORM_W'(grav_reg);
        diff    = (sqrt_root > g_ext) ? sqrt_root - g_ext : g_ext - sqrt_root;
        big_err = (grav_reg == '0);
        if (!big_err && div_quot < DIV_W'(err_low_reg)) begin
            tau = tau_low_reg;
        end else if (big_err || div_quot > DIV_W'(err_high_reg)) begin
            tau = tau_high_reg;
        end else begin
            tau = tau_mid_reg;
        end
        dt    = ts_reg - prev_time_reg;
        a_den = DIV_W'(tau) + DIV_W'(dt);
        a_num = DIV_W'({tau, FRAC_W'(0)}) + DIV_W'(a_den[DIV_W-1:1]);
    end

    always_comb begin
        state_next        = state_reg;
        lane_cmd.load     = 1'b0;
        lane_cmd.scale_go = 1'b0;
        lane_cmd.blend_go = 1'b0;
        lane_alpha        = ALPHA_ONE;
        sqrt_start        = 1'b0;
        div_start         = 1'b0;
        div_num           = DIV_W'({diff, FRAC_W'(0)});
        div_den           = DIV_W'(grav_reg);
        out_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser[0]) begin
                    lane_cmd.load = 1'b1;
                    state_next    = ST_LOADW;
                end
            end
            ST_LOADW: state_next = ST_SQS;
            ST_SQS: begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    if (sqrt_root == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        lane_cmd.scale_go = 1'b1;
                        div_start = !pass2_reg && (prev_time_reg != '0) && !big_err;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (lanes_scaled) begin
                    if (pass2_reg || prev_time_reg == '0) begin
                        state_next = ST_OUT;
                    end else if (a_den == '0) begin
                        lane_cmd.blend_go = 1'b1;
                        state_next        = ST_BLEND;
                    end else begin
                        div_start  = 1'b1;
                        div_num    = a_num;
                        div_den    = a_den;
                        state_next = ST_ALPHA;
                    end
                end
            end
            ST_ALPHA: begin
                lane_alpha = div_quot[ALPHA_W-1:0];
                if (div_done) begin
                    lane_cmd.blend_go = 1'b1;
                    state_next        = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (lanes_blended) begin
                    state_next = ST_SQS;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        galp_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (lane_cmd),
            .load_val (lane_in[i]),
            .grav     (grav_reg),
            .norm     (sqrt_root),
            .alpha    (lane_alpha),
            .prev     (prev_g_reg[i]),
            .sq       (lane_sq[i]),
            .scaled   (lane_scaled[i]),
            .sts      (lane_sts[i])
        );
    end

    galp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_sum),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    galp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            grav_reg      <= G_W'(10042);
            tau_low_reg   <= TAU_W'(400000);
            tau_mid_reg   <= TAU_W'(750000);
            tau_high_reg  <= TAU_W'(990000);
            err_low_reg   <= THR_W'(6554);
            err_high_reg  <= THR_W'(58982);
            prev_time_reg <= '0;
            for (int i = 0; i < LANES; i++) begin
                prev_g_reg[i] <= '0;
            end
            pass2_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_GRAV:     grav_reg     <= cfg_wdata[G_W-1:0];
                    REG_TAU_LOW:  tau_low_reg  <= cfg_wdata[TAU_W-1:0];
                    REG_TAU_MID:  tau_mid_reg  <= cfg_wdata[TAU_W-1:0];
                    REG_TAU_HIGH: tau_high_reg <= cfg_wdata[TAU_W-1:0];
                    REG_ERR_LOW:  err_low_reg  <= cfg_wdata[THR_W-1:0];
                    REG_ERR_HIGH: err_high_reg <= cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (lane_cmd.load) begin
                pass2_reg <= 1'b0;
                zero_reg  <= 1'b0;
            end
            if (state_reg == ST_BLEND && lanes_blended) begin
                pass2_reg <= 1'b1;
            end
            if (state_reg == ST_SQRT && sqrt_done && sqrt_root == '0) begin
                zero_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (!zero_reg) begin
                    prev_time_reg <= ts_reg;
                    for (int i = 0; i < LANES; i++) begin
                        prev_g_reg[i] <= lane_scaled[i];
                    end
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_cmd.load) begin
            acc_reg <= s_tdata[62:60];
            ts_reg  <= s_tdata[110:63];
        end
        if (out_load) begin
            m_user_reg <= zero_reg;
            m_data_reg <= {5'b0, ts_reg, acc_reg,
                           zero_reg ? GRAV_W'(0) : lane_scaled[2],
                           zero_reg ? GRAV_W'(0) : lane_scaled[1],
                           zero_reg ? GRAV_W'(0) : lane_scaled[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[47:0] == '0)
        else $error("zero_norm item carries a nonzero vector");

    a_hist_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(prev_time_reg) |-> $past(state_reg == ST_OUT) || !$past(aresetn))
        else $error("history changed outside output load");

    a_scale_st: assert property (@(posedge aclk) disable iff (!aresetn)
        lanes_scaled |-> state_reg == ST_SCALE)
        else $error("lane scale finished outside scale state");
`endif

endmodule

// ===== rtl/core/galp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module galp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [galp_pkg::DIV_W-1:0]  num,
    input  logic [galp_pkg::DIV_W-1:0]  den,
    output logic                        done,
    output logic [galp_pkg::DIV_W-1:0]  quot
);
    import galp_pkg::*;

    logic [DIV_W-1:0]     q_reg;
    logic [DIV_W-1:0]     d_reg;
    logic [DIV_W-1:0]     r_reg;
    logic [DIV_W-1:0]     r_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_W:0]       trial;
    logic                 fits;

    always_comb begin
        trial  = {r_reg, q_reg[DIV_W-1]};
        fits   = trial >= {1'b0, d_reg};
        r_next = fits ? DIV_W'(trial - {1'b0, d_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CNT_W'(DIV_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            d_reg <= den;
            r_reg <= '0;
        end else if (run_reg) begin
            r_reg <= r_next;
            q_reg <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/core/galp_sqrt.sv =====
// Integer square root, one result bit per cycle.
module galp_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [galp_pkg::SQ_W-1:0]   radicand,
    output logic                        done,
    output logic [galp_pkg::NORM_W-1:0] root
);
    import galp_pkg::*;

    logic [SQ_W-1:0]       v_reg;
    logic [NORM_W:0]       rem_reg;
    logic [NORM_W:0]       rem_next;
    logic [NORM_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [NORM_W+2:0]     rem_sh;
    logic [NORM_W+2:0]     trial;
    logic                  fits;

    always_comb begin
        rem_sh   = {rem_reg, v_reg[SQ_W-1:SQ_W-2]};
        trial    = {1'b0, root_reg, 2'b01};
        fits     = rem_sh >= trial;
        rem_next = fits ? (NORM_W+1)'(rem_sh - trial) : rem_sh[NORM_W:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= SQRT_CNT_W'(NORM_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            v_reg    <= {v_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[NORM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/galp_lane.sv =====
// One axis lane: square, rescale by division and alpha blend.
module galp_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  galp_pkg::lane_cmd_t                cmd,
    input  logic signed [galp_pkg::SAMPLE_W-1:0] load_val,
    input  logic [galp_pkg::G_W-1:0]           grav,
    input  logic [galp_pkg::NORM_W-1:0]        norm,
    input  logic [galp_pkg::ALPHA_W-1:0]       alpha,
    input  logic signed [galp_pkg::GRAV_W-1:0] prev,
    output logic [galp_pkg::SQ_W-1:0]          sq,
    output logic signed [galp_pkg::GRAV_W-1:0] scaled,
    output galp_pkg::lane_sts_t                sts
);
    import galp_pkg::*;

    logic signed [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0]        mag_val;
    logic [SQ_W-1:0]            sq_reg;
    logic [SAMPLE_W+G_W-1:0]    vg_prod;
    logic [DIV_W-1:0]           div_num;
    logic [DIV_W-1:0]           div_den;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quot;
    logic                       neg_reg;
    logic signed [GRAV_W-1:0]   scaled_reg;
    logic                       sdone_reg;
    logic signed [PROD_W-1:0]   pa_reg;
    logic signed [PROD_W-1:0]   pb_reg;
    logic signed [ALPHA_W:0]    a_s;
    logic signed [ALPHA_W:0]    b_s;
    logic signed [BLEND_W-1:0]  bsum;
    logic [BLEND_W-1:0]         bmag;
    logic [BLEND_W-FRAC_W-1:0]  bq;
    logic                       ph1_reg;
    logic                       ph2_reg;
    logic                       ph3_reg;

    always_comb begin
        mag_val = val_reg[SAMPLE_W-1] ? SAMPLE_W'(-val_reg) : SAMPLE_W'(val_reg);
        vg_prod = (SAMPLE_W+G_W)'(mag_val) * (SAMPLE_W+G_W)'(grav);
        div_num = DIV_W'({vg_prod, 1'b0}) + DIV_W'(norm);
        div_den = DIV_W'({norm, 1'b0});
        a_s     = $signed({1'b0, alpha});
        b_s     = $signed({1'b0, ALPHA_W'(ALPHA_ONE - alpha)});
        bsum    = BLEND_W'(pa_reg) + BLEND_W'(pb_reg);
        bmag    = bsum[BLEND_W-1] ? BLEND_W'(-bsum) : BLEND_W'(bsum);
        bq      = (BLEND_W-FRAC_W)'((bmag + BLEND_W'(ALPHA_ONE >> 1)) >> FRAC_W);
    end

    galp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.scale_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sdone_reg <= 1'b0;
            ph1_reg   <= 1'b0;
            ph2_reg   <= 1'b0;
            ph3_reg   <= 1'b0;
        end else begin
            sdone_reg <= div_done;
            ph1_reg   <= cmd.blend_go;
            ph2_reg   <= ph1_reg;
            ph3_reg   <= ph2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg <= SQ_W'(mag_val) * SQ_W'(mag_val);
        if (cmd.load) begin
            val_reg <= load_val;
        end else if (ph1_reg) begin
            val_reg <= bsum[BLEND_W-1] ? -SAMPLE_W'(bq) : SAMPLE_W'(bq);
        end
        if (cmd.scale_go) begin
            neg_reg <= val_reg[SAMPLE_W-1];
        end
        if (div_done) begin
            scaled_reg <= neg_reg ? -GRAV_W'(div_quot[GRAV_W-1:0])
                                  : GRAV_W'(div_quot[GRAV_W-1:0]);
        end
        if (cmd.blend_go) begin
            pa_reg <= PROD_W'(a_s) * PROD_W'(prev);
            pb_reg <= PROD_W'(b_s) * PROD_W'(scaled_reg);
        end
    end

    assign sq             = sq_reg;
    assign scaled         = scaled_reg;
    assign sts.scale_done = sdone_reg;
    assign sts.blend_done = ph3_reg;

endmodule

// ===== tb/gravity_adaptive_lowpass_top_tb.sv =====
// Testbench for the adaptive gravity low-pass filter: random and directed items checked
// against a built-in predictor.
module gravity_adaptive_lowpass_top_tb;
    import galp_pkg::*;

    typedef struct {
        logic signed [GRAV_W-1:0] gx, gy, gz;
        logic [2:0]               acc;
        logic [TIME_W-1:0]        ts;
        logic                     zn;
    } grav_res_t;

    class grav_scoreboard;
        bit [63:0] g_mag, tau_lo, tau_mid, tau_hi, thr_lo, thr_hi;
        bit [63:0] last_ts;
        longint    hist_x, hist_y, hist_z;
        grav_res_t awaited[$];
        int        errors;

        function void reset_state();
            g_mag = 10042; tau_lo = 400000; tau_mid = 750000; tau_hi = 990000;
            thr_lo = 6554; thr_hi = 58982;
            last_ts = 0; hist_x = 0; hist_y = 0; hist_z = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
            case (idx)
                REG_GRAV:     g_mag   = val[G_W-1:0];
                REG_TAU_LOW:  tau_lo  = val[TAU_W-1:0];
                REG_TAU_MID:  tau_mid = val[TAU_W-1:0];
                REG_TAU_HIGH: tau_hi  = val[TAU_W-1:0];
                REG_ERR_LOW:  thr_lo  = val[THR_W-1:0];
                REG_ERR_HIGH: thr_hi  = val[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] absv(longint v);
            return v < 0 ? -v : v;
        endfunction

        function bit [63:0] root(bit [63:0] v);
            bit [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function bit [63:0] vec_len(longint x, longint y, longint z);
            return root(absv(x) * absv(x) + absv(y) * absv(y) + absv(z) * absv(z));
        endfunction

        function longint to_mag(longint v, bit [63:0] g, bit [63:0] n);
            bit [63:0] q;
            q = (2 * absv(v) * g + n) / (2 * n);
            return v < 0 ? -longint'(q) : longint'(q);
        endfunction

        function longint frac_round(longint v);
            bit [63:0] q;
            q = (absv(v) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
            return v < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void note_item(bit ev, logic signed [SAMPLE_W-1:0] x, y, z,
                                logic [2:0] acc, logic [TIME_W-1:0] ts);
            grav_res_t r;
            longint sx, sy, sz, bx, by, bz, a, b;
            bit [63:0] n, nb, diff, err, tau, dt, alpha, den, t64;
            bit zero;
            if (!ev) return;
            zero = 0;
            t64 = ts;
            r.acc = acc;
            r.ts = ts;
            n = vec_len(x, y, z);
            if (n == 0) begin
                zero = 1;
            end else begin
                sx = to_mag(x, g_mag, n);
                sy = to_mag(y, g_mag, n);
                sz = to_mag(z, g_mag, n);
                if (last_ts != 0) begin
                    diff = n > g_mag ? n - g_mag : g_mag - n;
                    err = g_mag == 0 ? 0 : (diff << 16) / g_mag;
                    if (g_mag != 0 && err < thr_lo) tau = tau_lo;
                    else if (g_mag == 0 || err > thr_hi) tau = tau_hi;
                    else tau = tau_mid;
                    dt = (t64 - last_ts) & ((64'd1 << TIME_W) - 1);
                    if (dt > ~64'd0 - tau) begin
                        alpha = 0;
                    end else if (tau + dt == 0) begin
                        alpha = 64'd1 << FRAC_W;
                    end else begin
                        den = tau + dt;
                        alpha = ((tau << FRAC_W) + (den >> 1)) / den;
                    end
                    a = alpha;
                    b = (64'd1 << FRAC_W) - alpha;
                    bx = frac_round(a * hist_x + b * sx);
                    by = frac_round(a * hist_y + b * sy);
                    bz = frac_round(a * hist_z + b * sz);
                    nb = vec_len(bx, by, bz);
                    if (nb == 0) begin
                        zero = 1;
                    end else begin
                        sx = to_mag(bx, g_mag, nb);
                        sy = to_mag(by, g_mag, nb);
                        sz = to_mag(bz, g_mag, nb);
                    end
                end
            end
            if (zero) begin
                r.gx = 0; r.gy = 0; r.gz = 0; r.zn = 1;
            end else begin
                last_ts = t64;
                hist_x = sx; hist_y = sy; hist_z = sz;
                r.gx = sx; r.gy = sy; r.gz = sz; r.zn = 0;
            end
            awaited.push_back(r);
        endfunction

        function void check_result(grav_res_t got);
            grav_res_t e;
            if (awaited.size() == 0) begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (got.gx !== e.gx) begin
                $error("grav_x: expected %0d, got %0d", e.gx, got.gx); errors++;
            end
            if (got.gy !== e.gy) begin
                $error("grav_y: expected %0d, got %0d", e.gy, got.gy); errors++;
            end
            if (got.gz !== e.gz) begin
                $error("grav_z: expected %0d, got %0d", e.gz, got.gz); errors++;
            end
            if (got.acc !== e.acc) begin
                $error("accuracy_out: expected %0d, got %0d", e.acc, got.acc); errors++;
            end
            if (got.ts !== e.ts) begin
                $error("time_out: expected %0d, got %0d", e.ts, got.ts); errors++;
            end
            if (got.zn !== e.zn) begin
                $error("zero_norm: expected %0d, got %0d", e.zn, got.zn); errors++;
            end
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    grav_scoreboard grav_sb = new();
    int unsigned send_idle, recv_idle, recv_hold;
    logic [TIME_W-1:0] now_us;

    gravity_adaptive_lowpass_top dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        grav_res_t r;
        if (aresetn && s_tvalid && s_tready)
            grav_sb.note_item(s_tuser[0], s_tdata[19:0], s_tdata[39:20], s_tdata[59:40],
                              s_tdata[62:60], s_tdata[110:63]);
        if (aresetn && m_tvalid && m_tready) begin
            r.gx = m_tdata[15:0];
            r.gy = m_tdata[31:16];
            r.gz = m_tdata[47:32];
            r.acc = m_tdata[50:48];
            r.ts = m_tdata[98:51];
            r.zn = m_tuser[0];
            grav_sb.check_result(r);
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready <= 0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    task automatic send_item(bit ev, logic [SAMPLE_W-1:0] x, y, z, logic [2:0] acc,
                             logic [TIME_W-1:0] ts);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = ev;
        s_tdata = {1'b0, ts, acc, z, y, x};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic drain();
        while (grav_sb.awaited.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = val;
        grav_sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic load_setting(int k);
        logic [CFG_W-1:0] v[6];
        case (k % 5)
            0: v = '{10042, 400000, 750000, 990000, 6554, 58982};
            1: v = '{32767, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 65535, 65535};
            2: v = '{0, 0, 0, 0, 0, 0};
            3: v = '{1, 0, 24'hFFFFFF, 1000, 0, 65535};
            default: v = '{$urandom_range(32767), $urandom_range(24'hFFFFFF),
                           $urandom_range(2000000), $urandom_range(24'hFFFFFF),
                           $urandom_range(65535), $urandom_range(65535)};
        endcase
        write_reg(REG_GRAV, v[0]);
        write_reg(REG_TAU_LOW, v[1]);
        write_reg(REG_TAU_MID, v[2]);
        write_reg(REG_TAU_HIGH, v[3]);
        write_reg(REG_ERR_LOW, v[4]);
        write_reg(REG_ERR_HIGH, v[5]);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_axis(int kind);
        case (kind)
            0: return SAMPLE_W'($urandom);
            1: return 0;
            default: return SAMPLE_W'($signed($urandom_range(24000)) - 12000);
        endcase
    endfunction

    task automatic random_item();
        int k, r;
        k = $urandom_range(9) == 0 ? 0 : 2;
        r = $urandom_range(99);
        if (r < 2) now_us = 0;
        else if (r < 5) now_us = TIME_W'({$urandom, $urandom});
        else if (r < 7) now_us = now_us - $urandom_range(100000);
        else now_us = now_us + $urandom_range(1, 60000);
        send_item($urandom_range(19) != 0,
                  rand_axis($urandom_range(30) == 0 ? 1 : k),
                  rand_axis($urandom_range(30) == 0 ? 1 : k),
                  rand_axis($urandom_range(30) == 0 ? 1 : k),
                  3'($signed($urandom_range(4)) - 1), now_us);
    endtask

    task automatic directed_items();
        send_item(1, 20'h80000, 20'h80000, 20'h80000, 3'b111, 48'd1000);
        send_item(1, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 3'd0, 48'd21000);
        send_item(1, 0, 0, 0, 3'd1, 48'd41000);
        send_item(0, 20'h12345, 0, 0, 3'd2, 48'd50000);
        send_item(1, 0, 0, 10042, 3'd3, 48'd41000);
        send_item(1, 0, 10042, 0, 3'd2, 48'd41000);
        send_item(1, 20'h7FFFF, 0, 0, 3'd1, 48'hFFFF_FFFF_FFFF);
        send_item(1, 20'h80000, 0, 0, 3'd0, 48'd5);
        send_item(1, 0, 20'h7FFFF, 20'h80000, 3'b111, 48'd0);
        send_item(1, 1, 0, 0, 3'd3, 48'd10);
        send_item(1, 20'hFFFFF, 0, 0, 3'd2, 48'd20);
        send_item(1, 5000, 5000, 5000, 3'd1, 48'hFFFF_FFFF_FFF0);
        send_item(1, 20000, 0, 0, 3'd0, 48'd100);
        now_us = 48'd200;
    endtask

    initial begin
        grav_sb.reset_state();
        send_idle = 0;
        recv_idle = 0;
        recv_hold = 0;
        now_us = 1;
        repeat (11) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        for (int m = 0; m < 3; m++) begin
            send_idle = m == 0 ? 27 : (m == 1 ? 64 : 0);
            recv_idle = m == 0 ? 64 : (m == 1 ? 27 : 0);
            for (int p = 0; p < 5; p++) begin
                if (m > 0 || p > 0) begin
                    drain();
                    load_setting(p + m);
                end
                if (p == 0) directed_items();
                if (m == 2 && p == 1) recv_hold = 3000;
                for (int i = 0; i < 62; i++) begin
                    random_item();
                    if (i == 30 && p == 3) drain();
                end
            end
        end
        drain();
        if (grav_sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
